// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset.
`define DPB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Short form on the block's own clock and reset names.
`define DPB_ASSERT_CR(lbl, prop, msg) `DPB_ASSERT(lbl, clock, reset, prop, msg)

`endif

// ===== rtl/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg
// Types and constants of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

   localparam int DEPTH_W     = 16;
   localparam int COLOR_W     = 8;
   localparam int POINT_W     = 32;
   localparam int INV_W       = 32;
   localparam int CENTER_W    = 16;
   localparam int FRAME_W     = 12;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int FRAC_SHIFT  = 28;
   localparam int LO_W        = FRAC_SHIFT + DEPTH_W;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_INV_FOCAL_X  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_FOCAL_Y  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_X     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CENTER_Y     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

   // register reset values
   localparam logic [INV_W-1:0]    RST_INV_FOCAL  = 32'd7953544;
   localparam logic [CENTER_W-1:0] RST_CENTER_X   = 16'd7680;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y   = 16'd4320;
   localparam logic [FRAME_W-1:0]  RST_FRAME_W    = 12'd960;
   localparam logic [FRAME_W-1:0]  RST_FRAME_H    = 12'd540;

   localparam logic [LO_W-1:0]    ROUND_HALF   = LO_W'(64'd1 << (FRAC_SHIFT - 1));
   localparam logic [POINT_W-1:0] SAT_POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [POINT_W-1:0] SAT_NEG_MIN  = 32'h8000_0000;
   localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_OFF_X,
      ST_MUL_DEP_X,
      ST_SUM_X,
      ST_MUL_OFF_Y,
      ST_MUL_DEP_Y,
      ST_SUM_Y
   } state_type;

   typedef struct packed {
      logic capture;   // take the input transaction
      logic mul_off;   // offset times inverse focal length
      logic mul_dep;   // split product times depth
      logic store_x;   // keep rounded x
      logic load_out;  // fill output register (y sum taken here)
      logic axis_y;    // 1 selects the vertical axis
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being drained
   } status_type;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth_mm;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } req_payload_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_x;
      logic signed [POINT_W-1:0] point_y;
      logic [DEPTH_W-1:0]        point_z;
      logic                      point_valid;
      logic [COLOR_W-1:0]        out_blue;
      logic [COLOR_W-1:0]        out_green;
      logic [COLOR_W-1:0]        out_red;
      logic [COLOR_W-1:0]        out_alpha;
      logic                      end_of_row;
      logic                      end_of_frame;
   } rsp_payload_type;

endpackage

// ===== rtl/dpb_if.sv =====
// ----------------------------------------------------------------------------
// dpb channel interfaces
// Valid/ready channels for depth pixels in and points out.
// ----------------------------------------------------------------------------
interface dpb_req_if import dpb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_mm;
   logic [COLOR_W-1:0] blue;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] red;

   modport source (output valid, depth_mm, blue, green, red, input ready);
   modport sink   (input valid, depth_mm, blue, green, red, output ready);
endinterface

interface dpb_rsp_if import dpb_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [POINT_W-1:0] point_x;
   logic signed [POINT_W-1:0] point_y;
   logic [DEPTH_W-1:0]        point_z;
   logic                      point_valid;
   logic [COLOR_W-1:0]        out_blue;
   logic [COLOR_W-1:0]        out_green;
   logic [COLOR_W-1:0]        out_red;
   logic [COLOR_W-1:0]        out_alpha;
   logic                      end_of_row;
   logic                      end_of_frame;

   modport source (output valid, point_x, point_y, point_z, point_valid, out_blue,
                   out_green, out_red, out_alpha, end_of_row, end_of_frame,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_valid, out_blue,
                   out_green, out_red, out_alpha, end_of_row, end_of_frame,
                   output ready);
endinterface

// ===== rtl/dpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpb_ctrl
// Sequencer: accept, then offset/depth multiply and round for x, then y.
// ----------------------------------------------------------------------------
module dpb_ctrl import dpb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL_OFF_X;
            end
         end
         ST_MUL_OFF_X: begin
            cmd.mul_off = 1'b1;
            state_in    = ST_MUL_DEP_X;
         end
         ST_MUL_DEP_X: begin
            cmd.mul_dep = 1'b1;
            state_in    = ST_SUM_X;
         end
         ST_SUM_X: begin
            cmd.store_x = 1'b1;
            state_in    = ST_MUL_OFF_Y;
         end
         ST_MUL_OFF_Y: begin
            cmd.axis_y  = 1'b1;
            cmd.mul_off = 1'b1;
            state_in    = ST_MUL_DEP_Y;
         end
         ST_MUL_DEP_Y: begin
            cmd.axis_y  = 1'b1;
            cmd.mul_dep = 1'b1;
            state_in    = ST_SUM_Y;
         end
         ST_SUM_Y: begin
            cmd.axis_y = 1'b1;
            // hold here until the output register can take the point
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/dpb_datapath.sv =====
// ----------------------------------------------------------------------------
// dpb_datapath
// Registers, pixel counters, shared projection multipliers, output register.
// ----------------------------------------------------------------------------
module dpb_datapath import dpb_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  req_payload_type        req_payload,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output rsp_payload_type        rsp_payload,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int CNT_W  = COORD_BITS;
   localparam int POS_W  = COORD_BITS + 4;
   localparam int OFF_W  = (POS_W > CENTER_W) ? POS_W : CENTER_W;
   localparam int CMP_W  = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
   localparam int PROD_W = OFF_W + INV_W;
   localparam int PH_W   = PROD_W - FRAC_SHIFT;
   localparam int HI_W   = PH_W + DEPTH_W;
   localparam int MAG_W  = HI_W + 1;

   // configuration
   logic [INV_W-1:0]    inv_x_ff, inv_y_ff;
   logic [CENTER_W-1:0] cen_x_ff, cen_y_ff;
   logic [FRAME_W-1:0]  fw_ff, fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff <= RST_INV_FOCAL;
         inv_y_ff <= RST_INV_FOCAL;
         cen_x_ff <= RST_CENTER_X;
         cen_y_ff <= RST_CENTER_Y;
         fw_ff    <= RST_FRAME_W;
         fh_ff    <= RST_FRAME_H;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_INV_FOCAL_X:  inv_x_ff <= csr_wdata[INV_W-1:0];
            REG_INV_FOCAL_Y:  inv_y_ff <= csr_wdata[INV_W-1:0];
            REG_CENTER_X:     cen_x_ff <= csr_wdata[CENTER_W-1:0];
            REG_CENTER_Y:     cen_y_ff <= csr_wdata[CENTER_W-1:0];
            REG_FRAME_WIDTH:  fw_ff    <= csr_wdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT: fh_ff    <= csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // raster position
   logic [CNT_W-1:0]   col_ff, row_ff;
   logic [FRAME_W-1:0] wlast, hlast;
   logic               eor, eof;

   assign wlast = (fw_ff == '0) ? '0 : fw_ff - 1'b1;
   assign hlast = (fh_ff == '0) ? '0 : fh_ff - 1'b1;
   assign eor   = (CMP_W'(col_ff) >= CMP_W'(wlast)) || (col_ff == '1);
   assign eof   = eor && ((CMP_W'(row_ff) >= CMP_W'(hlast)) || (row_ff == '1));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.capture) begin
         col_ff <= eor ? '0 : col_ff + 1'b1;
         if (eor) begin
            row_ff <= eof ? '0 : row_ff + 1'b1;
         end
      end
   end

   // pixel offsets from the principal point, sign and magnitude
   logic [OFF_W-1:0] pos_x, pos_y, c_x, c_y;
   logic             neg_x, neg_y;

   assign pos_x = OFF_W'({col_ff, 4'b0});
   assign pos_y = OFF_W'({row_ff, 4'b0});
   assign c_x   = OFF_W'(cen_x_ff);
   assign c_y   = OFF_W'(cen_y_ff);
   assign neg_x = pos_x < c_x;
   assign neg_y = pos_y < c_y;

   logic [OFF_W-1:0]   off_x_ff, off_y_ff;
   logic               neg_x_ff, neg_y_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [COLOR_W-1:0] blue_ff, green_ff, red_ff;
   logic               eor_ff, eof_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         off_x_ff <= neg_x ? c_x - pos_x : pos_x - c_x;
         off_y_ff <= neg_y ? c_y - pos_y : pos_y - c_y;
         neg_x_ff <= neg_x;
         neg_y_ff <= neg_y;
         depth_ff <= req_payload.depth_mm;
         blue_ff  <= req_payload.blue;
         green_ff <= req_payload.green;
         red_ff   <= req_payload.red;
         eor_ff   <= eor;
         eof_ff   <= eof;
      end
   end

   // shared multiply chain
   logic [PROD_W-1:0] prod_ff;
   logic [HI_W-1:0]   hi_ff;
   logic [LO_W-1:0]   lo_ff;
   logic [OFF_W-1:0]  off_sel;
   logic [INV_W-1:0]  inv_sel;

   // axis select ahead of the one offset multiplier
   assign off_sel = cmd.axis_y ? off_y_ff : off_x_ff;
   assign inv_sel = cmd.axis_y ? inv_y_ff : inv_x_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_off) begin
         prod_ff <= PROD_W'(off_sel) * PROD_W'(inv_sel);
      end
      if (cmd.mul_dep) begin
         hi_ff <= HI_W'(prod_ff[PROD_W-1:FRAC_SHIFT]) * HI_W'(depth_ff);
         lo_ff <= LO_W'(prod_ff[FRAC_SHIFT-1:0]) * LO_W'(depth_ff);
      end
   end

   // round half away from zero, apply sign, saturate
   logic [LO_W-1:0]    lo_round;
   logic [MAG_W-1:0]   mag;
   logic               neg_sel;
   logic [POINT_W-1:0] sat;

   assign lo_round = lo_ff + ROUND_HALF;
   assign mag      = MAG_W'(hi_ff) + MAG_W'(lo_round >> FRAC_SHIFT);
   assign neg_sel  = cmd.axis_y ? neg_y_ff : neg_x_ff;

   always_comb begin
      if (neg_sel) begin
         sat = (mag > MAG_W'(SAT_NEG_MIN)) ? SAT_NEG_MIN : POINT_W'(0) - mag[POINT_W-1:0];
      end else begin
         sat = (mag > MAG_W'(SAT_POS_MAX)) ? SAT_POS_MAX : mag[POINT_W-1:0];
      end
   end

   logic [POINT_W-1:0] x_ff;

   always_ff @(posedge clock) begin
      if (cmd.store_x) begin
         x_ff <= sat;
      end
   end

   // output register
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   logic            hit;

   assign hit = depth_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff.point_x      <= hit ? x_ff : '0;
         out_ff.point_y      <= hit ? sat : '0;
         out_ff.point_z      <= depth_ff;
         out_ff.point_valid  <= hit;
         out_ff.out_blue     <= hit ? blue_ff : '0;
         out_ff.out_green    <= hit ? green_ff : '0;
         out_ff.out_red      <= hit ? red_ff : '0;
         out_ff.out_alpha    <= hit ? ALPHA_OPAQUE : '0;
         out_ff.end_of_row   <= eor_ff;
         out_ff.end_of_frame <= eof_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_payload     = out_ff;
   assign status.out_free = !out_valid_ff || rsp_ready;

endmodule

// ===== rtl/depth_pixel_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// Pinhole back-projection of a raster depth+color stream into 3-D points.
// ----------------------------------------------------------------------------
//   channel   dir   handshake                 carries
//   req_chan  in    valid/ready               depth_mm, blue, green, red
//   rsp_chan  out   valid/ready               point x/y/z, valid, BGRA, row/frame ends
//   csr_*     in    csr_write_en, no ready    register index and write data
//
// An accept step, then per axis offset * inverse focal, the split product
// times depth, and round/saturate, all on one shared multiply chain: a pixel
// is not taken until the last one has finished all steps, and its point lands
// in the output register at the final y step, which waits for room there.
// req_chan is ready only while the sequencer is idle; a point waiting in the
// output register does not block the next accept, only the final y step.
// Reset (synchronous) restores the register defaults and zeroes the counters.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit import dpb_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   dpb_req_if.sink                req_chan,
   dpb_rsp_if.source              rsp_chan
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            rsp_valid;
   logic            req_ready;

   // input transaction payload gathered into one struct for the datapath
   assign req_payload.depth_mm = req_chan.depth_mm;
   assign req_payload.blue     = req_chan.blue;
   assign req_payload.green    = req_chan.green;
   assign req_payload.red      = req_chan.red;
   assign req_chan.ready       = req_ready;

   // sequencer: idle/accept, then three steps per axis
   dpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, counters, multipliers and the output register
   dpb_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_payload  (req_payload),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .cmd          (cmd),
      .status       (status)
   );

   // result transaction out of the output register
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.point_x      = rsp_payload.point_x;
   assign rsp_chan.point_y      = rsp_payload.point_y;
   assign rsp_chan.point_z      = rsp_payload.point_z;
   assign rsp_chan.point_valid  = rsp_payload.point_valid;
   assign rsp_chan.out_blue     = rsp_payload.out_blue;
   assign rsp_chan.out_green    = rsp_payload.out_green;
   assign rsp_chan.out_red      = rsp_payload.out_red;
   assign rsp_chan.out_alpha    = rsp_payload.out_alpha;
   assign rsp_chan.end_of_row   = rsp_payload.end_of_row;
   assign rsp_chan.end_of_frame = rsp_payload.end_of_frame;

endmodule

// ===== rtl/dpb_checker.sv =====
// ----------------------------------------------------------------------------
// dpb_checker
// Port-level checks of the back-projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpb_checker import dpb_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [POINT_W-1:0] point_x,
   input logic signed [POINT_W-1:0] point_y,
   input logic [DEPTH_W-1:0]        point_z,
   input logic                      point_valid,
   input logic [COLOR_W-1:0]        out_blue,
   input logic [COLOR_W-1:0]        out_green,
   input logic [COLOR_W-1:0]        out_red,
   input logic [COLOR_W-1:0]        out_alpha,
   input logic                      end_of_row,
   input logic                      end_of_frame
);

   logic rsp_stall;
   logic pt_clear;
   logic pt_opaque;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign pt_clear  = point_x == 0 && point_y == 0 && point_z == '0 &&
                      {out_blue, out_green, out_red, out_alpha} == '0;
   assign pt_opaque = out_alpha == ALPHA_OPAQUE && point_z != '0;

   // a stalled point keeps its coordinates
   `DPB_ASSERT_CR(a_rsp_hold, rsp_stall |=> rsp_valid && $stable({point_x, point_y}), "point moved")

   // one pixel at a time: no accept right after an accept
   `DPB_ASSERT_CR(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "back-to-back accept")

   // empty depth gives a fully cleared point
   `DPB_ASSERT_CR(a_invalid_clear, rsp_valid && !point_valid |-> pt_clear, "invalid not cleared")

   // valid points are opaque with a real depth
   `DPB_ASSERT_CR(a_valid_alpha, rsp_valid && point_valid |-> pt_opaque, "valid not opaque")

   // frame end only on a row end
   `DPB_ASSERT_CR(a_eof_on_eor, rsp_valid && end_of_frame |-> end_of_row, "frame end, no row end")

endmodule

bind depth_pixel_backprojection_unit dpb_checker u_dpb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .point_x      (rsp_chan.point_x),
   .point_y      (rsp_chan.point_y),
   .point_z      (rsp_chan.point_z),
   .point_valid  (rsp_chan.point_valid),
   .out_blue     (rsp_chan.out_blue),
   .out_green    (rsp_chan.out_green),
   .out_red      (rsp_chan.out_red),
   .out_alpha    (rsp_chan.out_alpha),
   .end_of_row   (rsp_chan.end_of_row),
   .end_of_frame (rsp_chan.end_of_frame)
);

// ===== tb/tb_depth_pixel_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_unit
// Self-checking bench for the depth pixel back-projection unit. Random depth
// pixels go in on req_chan. An in-bench pinhole projector predicts every point,
// and each point taken from rsp_chan is compared field by field. Both channels
// idle and stall at random. Registers are reprogrammed between phases, once
// the unit has drained.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_unit;
   import dpb_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transaction or register write
   localparam int MAX_PRINTED = 100;

   // indexes past the register list; writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam logic [INV_W-1:0]    INV_MAX    = '1;
   localparam logic [CENTER_W-1:0] CENTER_MAX = '1;
   localparam logic [FRAME_W-1:0]  FRAME_MAX  = '1;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   dpb_req_if req_chan ();
   dpb_rsp_if rsp_chan ();

   depth_pixel_backprojection_unit #(.COORD_BITS(COORD_BITS)) dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan)
   );

   // ------------------------------------------------------------------------
   // Projector state: a private copy of the registers and the raster counters.
   // ------------------------------------------------------------------------
   logic [INV_W-1:0]      cfg_inv_x, cfg_inv_y;
   logic [CENTER_W-1:0]   cfg_center_x, cfg_center_y;
   logic [FRAME_W-1:0]    cfg_width, cfg_height;
   logic [COORD_BITS-1:0] col_count, row_count;

   req_payload_type pixel_queue[$];     // pixels waiting for the driver
   rsp_payload_type pending_points[$];  // predicted points, oldest first

   int  error_count;
   int  point_index;
   int  gap_left;
   int  stall_left;
   int  idle_cycles;
   bit  steady_flow;                   // no gaps or stalls while set
   req_payload_type next_pixel;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // One axis: signed Q.4 offset times Q0.32 inverse focal length times depth.
   // The product is split at bit 28 so depth multiplies each half; the low
   // half carries the round-half-up on the magnitude. Sign goes on last, then
   // saturation to the signed 32-bit range.
   // ------------------------------------------------------------------------
   function automatic logic [POINT_W-1:0] project_axis(
      input logic [COORD_BITS-1:0] count,
      input logic [CENTER_W-1:0]   center,
      input logic [INV_W-1:0]      inv,
      input logic [DEPTH_W-1:0]    depth
   );
      logic [63:0] pos, ctr, off, prod, hi, lo, mag;
      logic        neg;
      pos  = 64'(count) << 4;
      ctr  = 64'(center);
      neg  = pos < ctr;
      off  = neg ? ctr - pos : pos - ctr;
      prod = off * 64'(inv);
      hi   = prod >> 28;
      lo   = prod & ((64'd1 << 28) - 64'd1);
      mag  = hi * 64'(depth) + ((lo * 64'(depth) + (64'd1 << 27)) >> 28);
      if (neg) begin
         if (mag > 64'h8000_0000) mag = 64'h8000_0000;
         return POINT_W'(64'h1_0000_0000 - mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return POINT_W'(mag);
   endfunction

   // Predict the point for one accepted pixel and step the raster counters.
   task automatic backproject_pixel(input req_payload_type px);
      rsp_payload_type    pt;
      logic [FRAME_W-1:0] wlast, hlast;
      logic               eor, eof;
      // a zero width or height behaves like one
      wlast = (cfg_width != '0) ? cfg_width - 1'b1 : '0;
      hlast = (cfg_height != '0) ? cfg_height - 1'b1 : '0;
      eor = (col_count >= wlast) || (col_count == '1);
      eof = eor && ((row_count >= hlast) || (row_count == '1));
      pt = '0;
      if (px.depth_mm != '0) begin
         pt.point_x     = project_axis(col_count, cfg_center_x, cfg_inv_x, px.depth_mm);
         pt.point_y     = project_axis(row_count, cfg_center_y, cfg_inv_y, px.depth_mm);
         pt.point_z     = px.depth_mm;
         pt.point_valid = 1'b1;
         pt.out_blue    = px.blue;
         pt.out_green   = px.green;
         pt.out_red     = px.red;
         pt.out_alpha   = ALPHA_OPAQUE;
      end
      pt.end_of_row   = eor;
      pt.end_of_frame = eof;
      pending_points = {pending_points, pt};
      if (eor) begin
         col_count = '0;
         row_count = eof ? '0 : row_count + 1'b1;
      end else begin
         col_count = col_count + 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_PRINTED)
         $display("point %0d: %s got 0x%0h expected 0x%0h", point_index, what, got, want);
      error_count++;
   endtask

   task automatic check_point(input rsp_payload_type got);
      rsp_payload_type want;
      want = pending_points.pop_front();
      if (got.point_x !== want.point_x)
         report_mismatch("point_x", 64'(got.point_x), 64'(want.point_x));
      if (got.point_y !== want.point_y)
         report_mismatch("point_y", 64'(got.point_y), 64'(want.point_y));
      if (got.point_z !== want.point_z)
         report_mismatch("point_z", 64'(got.point_z), 64'(want.point_z));
      if (got.point_valid !== want.point_valid)
         report_mismatch("point_valid", 64'(got.point_valid), 64'(want.point_valid));
      if (got.out_blue !== want.out_blue)
         report_mismatch("out_blue", 64'(got.out_blue), 64'(want.out_blue));
      if (got.out_green !== want.out_green)
         report_mismatch("out_green", 64'(got.out_green), 64'(want.out_green));
      if (got.out_red !== want.out_red)
         report_mismatch("out_red", 64'(got.out_red), 64'(want.out_red));
      if (got.out_alpha !== want.out_alpha)
         report_mismatch("out_alpha", 64'(got.out_alpha), 64'(want.out_alpha));
      if (got.end_of_row !== want.end_of_row)
         report_mismatch("end_of_row", 64'(got.end_of_row), 64'(want.end_of_row));
      if (got.end_of_frame !== want.end_of_frame)
         report_mismatch("end_of_frame", 64'(got.end_of_frame), 64'(want.end_of_frame));
   endtask

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (steady_flow) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Depth is zero, full scale or tiny often enough to hit those corners.
   function automatic req_payload_type random_pixel();
      req_payload_type px;
      case ($urandom_range(0, 9))
         0:       px.depth_mm = '0;
         1:       px.depth_mm = '1;
         2:       px.depth_mm = DEPTH_W'($urandom_range(1, 15));
         default: px.depth_mm = DEPTH_W'($urandom_range(1, 65535));
      endcase
      px.blue  = COLOR_W'($urandom);
      px.green = COLOR_W'($urandom);
      px.red   = COLOR_W'($urandom);
      return px;
   endfunction

   task automatic queue_pixel(input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] b,
                              input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
      pixel_queue = {pixel_queue, req_payload_type'{depth, b, g, r}};
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pixel_queue = {pixel_queue, random_pixel()};
   endtask

   // ------------------------------------------------------------------------
   // Register writes drive csr_write_en high with index and data; the
   // private copy keeps only the bits the register holds.
   // ------------------------------------------------------------------------
   task automatic set_register(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         REG_INV_FOCAL_X:  cfg_inv_x    = data[INV_W-1:0];
         REG_INV_FOCAL_Y:  cfg_inv_y    = data[INV_W-1:0];
         REG_CENTER_X:     cfg_center_x = data[CENTER_W-1:0];
         REG_CENTER_Y:     cfg_center_y = data[CENTER_W-1:0];
         REG_FRAME_WIDTH:  cfg_width    = data[FRAME_W-1:0];
         REG_FRAME_HEIGHT: cfg_height   = data[FRAME_W-1:0];
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Holds the sender until the unit is empty: nothing queued, nothing
   // offered, every predicted point returned. Checked between edges so the
   // driver's last pick-up has settled.
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_chan.valid || pending_points.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [INV_W-1:0] random_inv();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return INV_MAX;
         2, 3:    return INV_W'($urandom_range(1_000_000, 40_000_000));
         default: return INV_W'($urandom);
      endcase
   endfunction

   function automatic logic [CENTER_W-1:0] random_center();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CENTER_MAX;
         default: return CENTER_W'($urandom);
      endcase
   endfunction

   // New random settings; each register is rewritten with good odds, center and
   // frame with junk above their width, sometimes with a stray write past the list.
   task automatic random_settings();
      logic [FRAME_W-1:0] w, h;
      w = ($urandom_range(0, 9) == 0) ? '0 : FRAME_W'($urandom_range(1, 24));
      h = ($urandom_range(0, 9) == 0) ? '0 : FRAME_W'($urandom_range(1, 6));
      if ($urandom_range(0, 3) != 0) set_register(REG_INV_FOCAL_X, random_inv());
      if ($urandom_range(0, 3) != 0) set_register(REG_INV_FOCAL_Y, random_inv());
      if ($urandom_range(0, 3) != 0)
         set_register(REG_CENTER_X, {16'($urandom), random_center()});
      if ($urandom_range(0, 3) != 0)
         set_register(REG_CENTER_Y, {16'($urandom), random_center()});
      if ($urandom_range(0, 3) != 0) set_register(REG_FRAME_WIDTH, {20'($urandom), w});
      if ($urandom_range(0, 3) != 0) set_register(REG_FRAME_HEIGHT, {20'($urandom), h});
      if ($urandom_range(0, 3) == 0) set_register(REG_SPARE_6, $urandom);
      close_writes();
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers the next queued pixel whenever the channel is free,
   // with a random gap after each transaction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (pixel_queue.size() != 0) begin
            next_pixel = pixel_queue.pop_front();
            req_chan.depth_mm <= next_pixel.depth_mm;
            req_chan.blue     <= next_pixel.blue;
            req_chan.green    <= next_pixel.green;
            req_chan.red      <= next_pixel.red;
            req_chan.valid    <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: ready drops for random stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // Input monitor: every accepted pixel gets its point predicted.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         backproject_pixel('{req_chan.depth_mm, req_chan.blue, req_chan.green, req_chan.red});
   end

   // Output monitor: every accepted point is checked against the oldest
   // prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_points.size() == 0)
            report_mismatch("unexpected point", 64'd0, 64'd0);
         else
            check_point('{rsp_chan.point_x, rsp_chan.point_y, rsp_chan.point_z,
                          rsp_chan.point_valid, rsp_chan.out_blue, rsp_chan.out_green,
                          rsp_chan.out_red, rsp_chan.out_alpha, rsp_chan.end_of_row,
                          rsp_chan.end_of_frame});
         point_index++;
      end
   end

   // Watchdog: any transaction or register write restarts the count.
   always @(posedge clock) begin
      if (reset || csr_write_en || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("depth_pixel_backprojection_unit verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = REG_INV_FOCAL_X;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.depth_mm = '0;
      req_chan.blue = '0;
      req_chan.green = '0;
      req_chan.red = '0;
      rsp_chan.ready = 1'b0;
      error_count = 0;
      point_index = 0;
      idle_cycles = 0;
      steady_flow = 1'b0;
      // reset defaults of the unit
      cfg_inv_x = RST_INV_FOCAL;
      cfg_inv_y = RST_INV_FOCAL;
      cfg_center_x = RST_CENTER_X;
      cfg_center_y = RST_CENTER_Y;
      cfg_width = RST_FRAME_W;
      cfg_height = RST_FRAME_H;
      col_count = '0;
      row_count = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero depth with color set, full-scale and unit depth,
      // all-zero and all-one colors.
      queue_pixel(16'd0, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(16'hFFFF, 8'h00, 8'h00, 8'h00);
      queue_pixel(16'd1, 8'hFF, 8'h00, 8'hFF);
      queue_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(16'd0, 8'h00, 8'h00, 8'h00);
      queue_pixel(16'h8000, 8'h55, 8'hAA, 8'h5A);
      wait_drained();

      // Every register once, with junk above the center and frame widths, plus
      // dropped writes past the list. Column counter already sits past the new
      // row end, so the next pixel closes a row. Center at max with max inverse
      // focal length drives x into negative saturation; zero inverse keeps y at 0.
      set_register(REG_INV_FOCAL_X, INV_MAX);
      set_register(REG_INV_FOCAL_Y, '0);
      set_register(REG_CENTER_X, 32'hA5A5_FFFF);
      set_register(REG_CENTER_Y, 32'h1234_0000);
      set_register(REG_FRAME_WIDTH, 32'hFFFF_F003);
      set_register(REG_FRAME_HEIGHT, 32'h0000_7002);
      set_register(REG_SPARE_6, 32'hDEAD_BEEF);
      set_register(REG_SPARE_7, 32'h0000_0001);
      close_writes();
      queue_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56);
      queue_pixel(16'hFFFF, 8'hFF, 8'h00, 8'h00);
      queue_pixel(16'd1, 8'h00, 8'hFF, 8'h00);
      queue_pixel(16'd0, 8'hAB, 8'hCD, 8'hEF);
      queue_pixel(16'd2, 8'h01, 8'h02, 8'h03);
      queue_pixel(16'h7FFF, 8'h80, 8'h80, 8'h80);
      queue_pixel(16'hFFFF, 8'hFE, 8'hFD, 8'hFC);
      queue_pixel(16'd0, 8'h00, 8'h00, 8'h00);
      queue_pixel(16'd3, 8'h0F, 8'hF0, 8'h0F);
      queue_pixel(16'd4096, 8'h33, 8'h66, 8'h99);
      queue_pixel(16'hFFFE, 8'hFF, 8'hFF, 8'hFF);
      queue_pixel(16'd1, 8'hFF, 8'hFF, 8'hFF);
      wait_drained();

      // Zero width and height count as one: every pixel ends row and frame.
      // Center y at max with max inverse: y saturates negative.
      set_register(REG_FRAME_WIDTH, 32'h0000_1000);
      set_register(REG_FRAME_HEIGHT, '0);
      set_register(REG_CENTER_X, '0);
      set_register(REG_CENTER_Y, 32'h0000_FFFF);
      set_register(REG_INV_FOCAL_Y, INV_MAX);
      set_register(REG_INV_FOCAL_X, 32'(RST_INV_FOCAL));
      close_writes();
      queue_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33);
      queue_pixel(16'd1, 8'h44, 8'h55, 8'h66);
      queue_pixel(16'd0, 8'h77, 8'h88, 8'h99);
      queue_pixel(16'd40000, 8'hAA, 8'hBB, 8'hCC);
      queue_pixel(16'hFFFF, 8'hDD, 8'hEE, 8'hFF);
      wait_drained();

      // Widest row: column climbs to a few hundred; center 0 with max
      // inverse pushes x into positive saturation.
      set_register(REG_FRAME_WIDTH, 32'(FRAME_MAX));
      set_register(REG_FRAME_HEIGHT, 32'd1);
      set_register(REG_CENTER_X, '0);
      set_register(REG_INV_FOCAL_X, INV_MAX);
      set_register(REG_CENTER_Y, 32'(RST_CENTER_Y));
      close_writes();
      queue_random(300);
      wait_drained();

      // Tallest frame: one pixel per row, row climbs to a few hundred.
      set_register(REG_FRAME_WIDTH, 32'd1);
      set_register(REG_FRAME_HEIGHT, 32'(FRAME_MAX));
      set_register(REG_CENTER_Y, '0);
      set_register(REG_INV_FOCAL_Y, random_inv());
      close_writes();
      queue_random(300);
      wait_drained();

      // Random phases. Some run with no gaps or stalls at all.
      for (int p = 0; p < 8; p++) begin
         random_settings();
         steady_flow = ($urandom_range(0, 3) == 0);
         queue_random(60);
         wait_drained();
      end
      steady_flow = 1'b0;

      // settle time for any stray point after the last expected one
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("depth_pixel_backprojection_unit verification clean");
      else
         $display("depth_pixel_backprojection_unit verification failed");
      $finish;
   end

endmodule

// ===== depth_pixel_backprojection_unit.f =====
+incdir+rtl
rtl/dpb_pkg.sv
rtl/dpb_if.sv
rtl/dpb_ctrl.sv
rtl/dpb_datapath.sv
rtl/depth_pixel_backprojection_unit.sv
rtl/dpb_checker.sv
tb/tb_depth_pixel_backprojection_unit.sv
